/* rtl/assert_macros.svh */
// Assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is low
`define CHK_IMPLY(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error("assertion failed");

// Next-cycle implication, masked while reset is low
`define CHK_NEXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error("assertion failed");

// Next-cycle implication that also holds across reset
`define CHK_NEXT_ALWAYS(lbl, ant, con) \
  lbl: assert property (@(posedge clk) (ant) |=> (con)) \
    else $error("assertion failed");

`endif

/* rtl/rrqs_pkg.sv */
// Package: sizes, codes and cell structs of the round-robin scheduler
package rrqs_pkg;

  localparam int MAX_PROCS = 16;
  localparam int IDX_W     = $clog2(MAX_PROCS);
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);
  localparam int TIME_W    = 21;

  localparam logic [1:0] ACT_ADMIT    = 2'd0;
  localparam logic [1:0] ACT_DISPATCH = 2'd1;
  localparam logic [1:0] ACT_CLEAR    = 2'd2;

  localparam logic [1:0] ST_SLICE   = 2'd0;
  localparam logic [1:0] ST_ALLDONE = 2'd1;
  localparam logic [1:0] ST_REJECT  = 2'd2;

  localparam logic REG_QUANTUM = 1'b0;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic              clear;
    logic              admit;
    logic [IDX_W-1:0]  wr_idx;
    logic [7:0]        pid;
    logic [15:0]       arrival;
    logic [15:0]       burst;
    logic              flush;
    logic [TIME_W-1:0] now;
    logic              run_we;
    logic [IDX_W-1:0]  run_idx;
    logic [15:0]       rem_nxt;
  } cell_ctl_t;

  // What one cell shows the controller
  typedef struct packed {
    logic              push;
    logic              late;
    logic [7:0]        pid;
    logic [15:0]       arrival;
    logic [15:0]       burst;
    logic [15:0]       remaining;
    logic [TIME_W-1:0] first_start;
  } cell_st_t;

endpackage

/* rtl/rrqs_if.sv */
// Valid/ready channel interfaces for items in and results out
interface rrqs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  pid;
  logic [15:0] arrival;
  logic [15:0] burst;
  modport source (output valid, action, pid, arrival, burst, input ready);
  modport sink (input valid, action, pid, arrival, burst, output ready);
endinterface

interface rrqs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  run_pid;
  logic [20:0] slice_start;
  logic [20:0] slice_end;
  logic        finished;
  logic [20:0] first_start;
  logic [20:0] turnaround;
  logic [20:0] waiting;
  modport source (output valid, status, run_pid, slice_start, slice_end, finished,
                  first_start, turnaround, waiting, input ready);
  modport sink (input valid, status, run_pid, slice_start, slice_end, finished,
                first_start, turnaround, waiting, output ready);
endinterface

/* rtl/rrqs_cell.sv */
// One process-table cell: holds an entry and passes the scan token on
module rrqs_cell
  import rrqs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] cell_idx,
  input  cell_ctl_t        ctl,
  input  logic             tok_in,
  output logic             tok_out,
  output cell_st_t         st
);

  logic              loaded_r, queued_r, started_r, tok_r;
  logic [7:0]        pid_r;
  logic [15:0]       arr_r, burst_r, rem_r;
  logic [TIME_W-1:0] fs_r;
  logic              wr_sel, run_sel, active, arrived;

  assign wr_sel  = ctl.admit && (ctl.wr_idx == cell_idx);
  assign run_sel = ctl.run_we && (ctl.run_idx == cell_idx);
  assign active  = tok_r && loaded_r && !queued_r;
  assign arrived = {{(TIME_W-16){1'b0}}, arr_r} <= ctl.now;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r  <= 1'b0;
      queued_r  <= 1'b0;
      started_r <= 1'b0;
      tok_r     <= 1'b0;
    end else begin
      tok_r <= ctl.flush ? 1'b0 : tok_in;
      if (ctl.clear) begin
        loaded_r  <= 1'b0;
        queued_r  <= 1'b0;
        started_r <= 1'b0;
      end else if (wr_sel) begin
        loaded_r  <= 1'b1;
        queued_r  <= 1'b0;
        started_r <= 1'b0;
      end else begin
        if (active && arrived) queued_r <= 1'b1;
        if (run_sel) started_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_sel) begin
      pid_r   <= ctl.pid;
      arr_r   <= ctl.arrival;
      burst_r <= ctl.burst;
      rem_r   <= ctl.burst;
      fs_r    <= '0;
    end else if (run_sel) begin
      rem_r <= ctl.rem_nxt;
      if (!started_r) fs_r <= ctl.now;
    end
  end

  assign tok_out        = tok_r;
  assign st.push        = active && arrived;
  assign st.late        = active && !arrived;
  assign st.pid         = pid_r;
  assign st.arrival     = arr_r;
  assign st.burst       = burst_r;
  assign st.remaining   = rem_r;
  assign st.first_start = fs_r;

endmodule

/* rtl/round_robin_quantum_scheduler.sv */
// Round-robin quantum scheduler: a row of MAX_PROCS table cells, ready queue and sequencer.
// Clear, unused actions and accepted admits are handled in the idle state; a rejected admit
// posts a result. A dispatch passes a scan token along the cell row one cell per cycle; a
// dispatch that finds the queue empty with a process still to arrive jumps time and scans
// a second time. After scanning, the slice goes through check, pop, load and execute, then
// turnaround and waiting when the process finishes, and emit posts the result. One item
// is worked on at a time; a result waits in the output register while the next is taken.
module round_robin_quantum_scheduler
  import rrqs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  rrqs_in_if.sink     in_if,
  rrqs_out_if.source  out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SCAN  = 9'b000000010,
    S_CHECK = 9'b000000100,
    S_POP   = 9'b000001000,
    S_LOAD  = 9'b000010000,
    S_EXEC  = 9'b000100000,
    S_TAT   = 9'b001000000,
    S_WAIT  = 9'b010000000,
    S_EMIT  = 9'b100000000
  } state_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [7:0]        run_pid;
    logic [TIME_W-1:0] slice_start;
    logic [TIME_W-1:0] slice_end;
    logic              finished;
    logic [TIME_W-1:0] first_start;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;
  } res_t;

  function automatic res_t flag_res(logic [1:0] code);
    res_t r;
    r        = '0;
    r.status = code;
    return r;
  endfunction

  state_t            state_r;
  logic [15:0]       quantum_r;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic [CNT_W-1:0]  loaded_r, done_r, fcnt_r;
  logic [IDX_W-1:0]  scan_cnt_r, head_r, tail_r, cur_idx_r;
  logic              pass_r, any_r, out_valid_r;
  logic [15:0]       best_r;
  logic [IDX_W-1:0]  fifo_q [MAX_PROCS];
  logic [7:0]        cur_pid_r;
  logic [15:0]       cur_arr_r, cur_burst_r, cur_rem_r;
  res_t              res_r, out_r;
  res_t              slice_res, tat_res;

  cell_ctl_t         ctl;
  cell_st_t          cst [MAX_PROCS];
  cell_st_t          sel_st;
  logic [MAX_PROCS-1:0] tok;
  logic              scan_go, scan_last, in_acc;
  logic              push_any, late_any;
  logic [IDX_W-1:0]  push_idx;
  logic [15:0]       late_arr, q_eff, run, rem_nxt;
  logic              fifo_room;

  assign in_acc    = in_if.valid && in_if.ready;
  assign in_if.ready = (state_r == S_IDLE);
  assign scan_last = (CNT_W'(scan_cnt_r) + 1'b1) == loaded_r;
  assign fifo_room = fcnt_r < CNT_W'(MAX_PROCS);
  assign q_eff     = (quantum_r == 16'd0) ? 16'd1 : quantum_r;
  assign run       = (cur_rem_r < q_eff) ? cur_rem_r : q_eff;
  assign rem_nxt   = cur_rem_r - run;
  assign now_nxt   = now_r + TIME_W'(run);
  assign sel_st    = cst[cur_idx_r];

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == 3'b000) ? {16'd0, quantum_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_r <= 16'd4;
    end else if (psel && penable && pwrite && (paddr[2] == REG_QUANTUM)) begin
      quantum_r <= pwdata[15:0];
    end
  end

  // broadcast to the cell row
  always_comb begin
    ctl         = '0;
    ctl.wr_idx  = loaded_r[IDX_W-1:0];
    ctl.pid     = in_if.pid;
    ctl.arrival = in_if.arrival;
    ctl.burst   = in_if.burst;
    ctl.now     = now_r;
    ctl.run_idx = cur_idx_r;
    ctl.rem_nxt = rem_nxt;
    ctl.admit   = in_acc && (in_if.action == ACT_ADMIT) && (loaded_r < CNT_W'(MAX_PROCS));
    ctl.clear   = in_acc && (in_if.action == ACT_CLEAR);
    ctl.flush   = (state_r == S_SCAN) && scan_last;
    ctl.run_we  = (state_r == S_EXEC);
    scan_go = (in_acc && (in_if.action == ACT_DISPATCH) && (done_r < loaded_r)) ||
              ((state_r == S_CHECK) && (fcnt_r == '0) && !pass_r && any_r);
  end

  // slice result, and the same result with completion times added
  always_comb begin
    slice_res             = '0;
    slice_res.status      = ST_SLICE;
    slice_res.run_pid     = cur_pid_r;
    slice_res.slice_start = now_r;
    slice_res.slice_end   = now_nxt;
    slice_res.finished    = (rem_nxt == 16'd0);
    tat_res               = res_r;
    tat_res.first_start   = sel_st.first_start;
    tat_res.turnaround    = now_r - {{(TIME_W-16){1'b0}}, cur_arr_r};
  end

  for (genvar i = 0; i < MAX_PROCS; i++) begin : g_cell
    rrqs_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(i)),
      .ctl      (ctl),
      .tok_in   ((i == 0) ? scan_go : tok[(i == 0) ? 0 : i-1]),
      .tok_out  (tok[i]),
      .st       (cst[i])
    );
  end

  // gather the one cell that holds the token
  always_comb begin
    push_any = 1'b0;
    late_any = 1'b0;
    push_idx = '0;
    late_arr = '0;
    for (int i = 0; i < MAX_PROCS; i++) begin
      if (cst[i].push) begin
        push_any = 1'b1;
        push_idx = push_idx | IDX_W'(i);
      end
      if (cst[i].late) begin
        late_any = 1'b1;
        late_arr = late_arr | cst[i].arrival;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (((state_r == S_SCAN) && push_any && fifo_room) ||
        ((state_r == S_EXEC) && (rem_nxt != 16'd0) && fifo_room)) begin
      fifo_q[tail_r] <= (state_r == S_SCAN) ? push_idx : cur_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      now_r       <= '0;
      loaded_r    <= '0;
      done_r      <= '0;
      fcnt_r      <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      scan_cnt_r  <= '0;
      pass_r      <= 1'b0;
      any_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_if.ready && (state_r != S_EMIT)) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            priority if (in_if.action == ACT_ADMIT) begin
              if (ctl.admit) begin
                loaded_r <= loaded_r + 1'b1;
              end else begin
                res_r   <= flag_res(ST_REJECT);
                state_r <= S_EMIT;
              end
            end else if (in_if.action == ACT_DISPATCH) begin
              if (scan_go) begin
                pass_r     <= 1'b0;
                any_r      <= 1'b0;
                scan_cnt_r <= '0;
                state_r    <= S_SCAN;
              end else begin
                res_r   <= flag_res(ST_ALLDONE);
                state_r <= S_EMIT;
              end
            end else if (in_if.action == ACT_CLEAR) begin
              loaded_r <= '0;
              done_r   <= '0;
              now_r    <= '0;
              fcnt_r   <= '0;
              head_r   <= '0;
              tail_r   <= '0;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_SCAN: begin
          if (push_any && fifo_room) begin
            tail_r <= (tail_r == IDX_W'(MAX_PROCS-1)) ? '0 : tail_r + 1'b1;
            fcnt_r <= fcnt_r + 1'b1;
          end
          // keep the earliest arrival still pending
          if (late_any && (!any_r || (late_arr < best_r))) begin
            best_r <= late_arr;
            any_r  <= 1'b1;
          end
          scan_cnt_r <= scan_cnt_r + 1'b1;
          if (scan_last) state_r <= S_CHECK;
        end
        S_CHECK: begin
          if (fcnt_r != '0) begin
            state_r <= S_POP;
          end else if (scan_go) begin
            now_r      <= {{(TIME_W-16){1'b0}}, best_r};
            pass_r     <= 1'b1;
            any_r      <= 1'b0;
            scan_cnt_r <= '0;
            state_r    <= S_SCAN;
          end else begin
            res_r   <= flag_res(ST_ALLDONE);
            state_r <= S_EMIT;
          end
        end
        S_POP: begin
          cur_idx_r <= fifo_q[head_r];
          head_r    <= (head_r == IDX_W'(MAX_PROCS-1)) ? '0 : head_r + 1'b1;
          fcnt_r    <= fcnt_r - 1'b1;
          state_r   <= S_LOAD;
        end
        S_LOAD: begin
          cur_pid_r   <= sel_st.pid;
          cur_arr_r   <= sel_st.arrival;
          cur_burst_r <= sel_st.burst;
          cur_rem_r   <= sel_st.remaining;
          state_r     <= S_EXEC;
        end
        S_EXEC: begin
          res_r <= slice_res;
          now_r <= now_nxt;
          if (rem_nxt == 16'd0) begin
            done_r  <= done_r + 1'b1;
            state_r <= S_TAT;
          end else begin
            // requeue ahead of anything that arrived during the slice
            if (fifo_room) begin
              tail_r <= (tail_r == IDX_W'(MAX_PROCS-1)) ? '0 : tail_r + 1'b1;
              fcnt_r <= fcnt_r + 1'b1;
            end
            state_r <= S_EMIT;
          end
        end
        S_TAT: begin
          res_r   <= tat_res;
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          res_r.waiting <= res_r.turnaround - {{(TIME_W-16){1'b0}}, cur_burst_r};
          state_r       <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid_r || out_if.ready) begin
            out_r       <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.status      = out_r.status;
  assign out_if.run_pid     = out_r.run_pid;
  assign out_if.slice_start = out_r.slice_start;
  assign out_if.slice_end   = out_r.slice_end;
  assign out_if.finished    = out_r.finished;
  assign out_if.first_start = out_r.first_start;
  assign out_if.turnaround  = out_r.turnaround;
  assign out_if.waiting     = out_r.waiting;

endmodule

/* rtl/rrqs_chk.sv */
// Port-level checker for the scheduler, bound to the top level
`include "assert_macros.svh"

module rrqs_chk
  import rrqs_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [7:0]  run_pid,
  input logic [20:0] slice_start,
  input logic [20:0] slice_end,
  input logic        finished,
  input logic [20:0] first_start,
  input logic [20:0] turnaround,
  input logic [20:0] waiting
);

  `CHK_NEXT_ALWAYS(a_reset_quiet, !rst_n, !out_valid)
  `CHK_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(slice_end) && $stable(status))
  `CHK_IMPLY(a_flag_zero, out_valid && (status != ST_SLICE), run_pid == 8'd0 && !finished && slice_start == 21'd0 && slice_end == 21'd0)
  `CHK_IMPLY(a_open_zero, out_valid && (status == ST_SLICE) && !finished, first_start == 21'd0 && turnaround == 21'd0 && waiting == 21'd0)

endmodule

bind round_robin_quantum_scheduler rrqs_chk u_rrqs_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .status      (out_if.status),
  .run_pid     (out_if.run_pid),
  .slice_start (out_if.slice_start),
  .slice_end   (out_if.slice_end),
  .finished    (out_if.finished),
  .first_start (out_if.first_start),
  .turnaround  (out_if.turnaround),
  .waiting     (out_if.waiting)
);

/* tb/sv/round_robin_quantum_scheduler_tb.sv */
// Self-checking testbench for the round-robin quantum scheduler
`timescale 1ns / 100ps

module round_robin_quantum_scheduler_tb;
  import rrqs_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  run_pid;
    logic [20:0] slice_start;
    logic [20:0] slice_end;
    logic        finished;
    logic [20:0] first_start;
    logic [20:0] turnaround;
    logic [20:0] waiting;
  } slice_rec_t;

  localparam int WATCHDOG = 20000;
  localparam logic [2:0] QUANTUM_ADDR = 3'(4 * REG_QUANTUM);
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  rrqs_in_if in_ch();
  rrqs_out_if out_ch();

  round_robin_quantum_scheduler uut (
    .clk(clk), .rst_n(rst_n), .in_if(in_ch.sink), .out_if(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = '0;
    in_ch.pid = '0;
    in_ch.arrival = '0;
    in_ch.burst = '0;
    out_ch.ready = 1'b0;
  end

  // predictor state
  logic [15:0] quantum_q;
  logic [7:0]  t_id [MAX_PROCS];
  logic [15:0] t_arr [MAX_PROCS];
  logic [15:0] t_burst [MAX_PROCS];
  logic [15:0] t_rem [MAX_PROCS];
  logic [20:0] t_first [MAX_PROCS];
  logic        t_started [MAX_PROCS];
  logic        t_queued [MAX_PROCS];
  int          rq [$];
  int          n_loaded, n_done;
  logic [20:0] now_t;

  slice_rec_t expected_slices [$];
  int fail_count = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;

  function automatic void clear_table();
    rq.delete();
    n_loaded = 0;
    n_done = 0;
    now_t = '0;
    for (int i = 0; i < MAX_PROCS; i++) begin
      t_started[i] = 1'b0;
      t_queued[i] = 1'b0;
    end
  endfunction

  function automatic void queue_arrivals();
    for (int i = 0; i < n_loaded; i++)
      if (!t_queued[i] && 21'(t_arr[i]) <= now_t) begin
        t_queued[i] = 1'b1;
        rq.insert(rq.size(), i);
      end
  endfunction

  function automatic void schedule_item(logic [1:0] act, logic [7:0] pid,
                                        logic [15:0] arr, logic [15:0] bst);
    slice_rec_t r;
    int idx;
    bit any;
    logic [15:0] best, q, run;
    logic [20:0] tat;
    r = '0;
    if (act == ACT_ADMIT) begin
      if (n_loaded >= MAX_PROCS) begin
        r.status = ST_REJECT;
        expected_slices.insert(expected_slices.size(), r);
      end else begin
        t_id[n_loaded] = pid;
        t_arr[n_loaded] = arr;
        t_burst[n_loaded] = bst;
        t_rem[n_loaded] = bst;
        t_first[n_loaded] = '0;
        t_started[n_loaded] = 1'b0;
        t_queued[n_loaded] = 1'b0;
        n_loaded++;
      end
    end else if (act == ACT_CLEAR) begin
      clear_table();
    end else if (act == ACT_DISPATCH) begin
      r.status = ST_ALLDONE;
      if (n_done >= n_loaded) begin
        expected_slices.insert(expected_slices.size(), r);
        return;
      end
      queue_arrivals();
      if (rq.size() == 0) begin
        any = 1'b0;
        best = '0;
        for (int i = 0; i < n_loaded; i++)
          if (!t_queued[i] && (!any || t_arr[i] < best)) begin
            best = t_arr[i];
            any = 1'b1;
          end
        if (!any) begin
          expected_slices.insert(expected_slices.size(), r);
          return;
        end
        now_t = 21'(best);
        queue_arrivals();
      end
      idx = rq.pop_front();
      if (!t_started[idx]) begin
        t_started[idx] = 1'b1;
        t_first[idx] = now_t;
      end
      q = (quantum_q == 0) ? 16'd1 : quantum_q;
      run = (t_rem[idx] < q) ? t_rem[idx] : q;
      r.status = ST_SLICE;
      r.run_pid = t_id[idx];
      r.slice_start = now_t;
      now_t = now_t + 21'(run);
      t_rem[idx] = t_rem[idx] - run;
      r.slice_end = now_t;
      if (t_rem[idx] == 0) begin
        tat = now_t - 21'(t_arr[idx]);
        n_done++;
        r.finished = 1'b1;
        r.first_start = t_first[idx];
        r.turnaround = tat;
        r.waiting = tat - 21'(t_burst[idx]);
      end else begin
        rq.insert(rq.size(), idx);
      end
      expected_slices.insert(expected_slices.size(), r);
    end
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // valid stays high between items sent back to back; drop it only for a gap
  task automatic send_item(logic [1:0] act, logic [7:0] pid, logic [15:0] arr,
                           logic [15:0] bst, bit gaps = 1'b1);
    int g;
    g = gaps ? pick_gap() : 0;
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    schedule_item(act, pid, arr, bst);
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.pid <= pid;
    in_ch.arrival <= arr;
    in_ch.burst <= bst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // drain, then let any in-flight silent item finish before a register write
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_slices.size() != 0) @(posedge clk);
    repeat (2 * MAX_PROCS + 12) @(posedge clk);
  endtask

  task automatic write_quantum(logic [15:0] v);
    wait_idle();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= QUANTUM_ADDR;
    pwdata <= {16'h0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    quantum_q = v;
  endtask

  // result checker
  always @(posedge clk) begin
    slice_rec_t a, e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      a = '{out_ch.status, out_ch.run_pid, out_ch.slice_start, out_ch.slice_end,
            out_ch.finished, out_ch.first_start, out_ch.turnaround, out_ch.waiting};
      if (expected_slices.size() == 0) begin
        $error("unexpected result status=%0d pid=%0d", a.status, a.run_pid);
        fail_count++;
      end else begin
        e = expected_slices.pop_front();
        if (a.status != e.status) begin
          $error("status expected %0d actual %0d", e.status, a.status); fail_count++;
        end
        if (a.run_pid != e.run_pid) begin
          $error("run_pid expected %0d actual %0d", e.run_pid, a.run_pid); fail_count++;
        end
        if (a.slice_start != e.slice_start) begin
          $error("slice_start expected %0d actual %0d", e.slice_start, a.slice_start);
          fail_count++;
        end
        if (a.slice_end != e.slice_end) begin
          $error("slice_end expected %0d actual %0d", e.slice_end, a.slice_end);
          fail_count++;
        end
        if (a.finished != e.finished) begin
          $error("finished expected %0d actual %0d", e.finished, a.finished); fail_count++;
        end
        if (a.first_start != e.first_start) begin
          $error("first_start expected %0d actual %0d", e.first_start, a.first_start);
          fail_count++;
        end
        if (a.turnaround != e.turnaround) begin
          $error("turnaround expected %0d actual %0d", e.turnaround, a.turnaround);
          fail_count++;
        end
        if (a.waiting != e.waiting) begin
          $error("waiting expected %0d actual %0d", e.waiting, a.waiting); fail_count++;
        end
      end
    end
  end

  // receiver: random stalls, or hold fully while hold_off is set
  always @(posedge clk) begin
    int g;
    if (hold_off) begin
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 99) < 60) begin
      out_ch.ready <= 1'b1;
    end else begin
      g = pick_gap();
      out_ch.ready <= (g == 0);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic test_directed();
    send_item(ACT_DISPATCH, 8'h0, 16'h0, 16'h0);
    send_item(ACT_ADMIT, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_item(ACT_ADMIT, 8'h00, 16'h0000, 16'h0000);
    send_item(ACT_ADMIT, 8'h5A, 16'h0002, 16'h0009);
    send_item(ACT_ADMIT, 8'hA5, 16'h0003, 16'h0003);
    send_item(ACT_UNUSED, 8'h11, 16'h1, 16'h1);
    repeat (6) send_item(ACT_DISPATCH, 8'h0, 16'h0, 16'h0);
    send_item(ACT_CLEAR, 8'h0, 16'h0, 16'h0);
    for (int i = 0; i < MAX_PROCS + 1; i++)
      send_item(ACT_ADMIT, 8'(i), 16'(i), 16'(i % 3));
    send_item(ACT_DISPATCH, 8'h0, 16'h0, 16'h0);
  endtask

  task automatic test_quantum_settings();
    logic [15:0] qs [4] = '{16'd0, 16'd1, 16'hFFFF, 16'd3};
    foreach (qs[k]) begin
      write_quantum(qs[k]);
      send_item(ACT_CLEAR, 8'h0, 16'h0, 16'h0);
      for (int i = 0; i < 4; i++)
        send_item(ACT_ADMIT, 8'($urandom), 16'($urandom_range(0, 20)),
                  16'($urandom_range(0, 12)));
      repeat (14) send_item(ACT_DISPATCH, 8'h0, 16'h0, 16'h0);
    end
  endtask

  // full table, receiver blocked so the block back-pressures its input
  task automatic test_back_pressure();
    int held;
    write_quantum(16'd2);
    send_item(ACT_CLEAR, 8'h0, 16'h0, 16'h0, 1'b0);
    hold_off = 1'b1;
    fork
      begin
        held = 0;
        while (held < 300) begin
          @(posedge clk);
          held++;
        end
        hold_off = 1'b0;
      end
      begin
        for (int i = 0; i < MAX_PROCS + 2; i++)
          send_item(ACT_ADMIT, 8'($urandom), 16'($urandom_range(0, 8)),
                    16'($urandom_range(1, 5)), 1'b0);
        repeat (20) send_item(ACT_DISPATCH, 8'h0, 16'h0, 16'h0, 1'b0);
      end
    join
  endtask

  task automatic test_random();
    int sent, n, p;
    logic [15:0] amax, bmax;
    sent = 0;
    while (sent < 1150) begin
      if (sent % 300 == 0)
        write_quantum(($urandom_range(0, 3) == 0) ? 16'($urandom) :
                      16'($urandom_range(0, 8)));
      send_item(ACT_CLEAR, 8'h0, 16'h0, 16'h0);
      n = $urandom_range(1, MAX_PROCS + 1);
      p = $urandom_range(0, 9);
      amax = (p == 0) ? 16'hFFFF : 16'd40;
      bmax = (p == 1) ? 16'hFFFF : 16'd15;
      for (int i = 0; i < n; i++)
        send_item(ACT_ADMIT, 8'($urandom), 16'($urandom_range(0, amax)),
                  16'($urandom_range(0, bmax)));
      sent += n + 1;
      for (int i = 0; i < 3 * n + 4; i++) begin
        p = $urandom_range(0, 99);
        if (p < 90)
          send_item(ACT_DISPATCH, 8'($urandom), 16'($urandom), 16'($urandom));
        else if (p < 96)
          send_item(ACT_ADMIT, 8'($urandom), 16'($urandom), 16'($urandom_range(0, 20)));
        else
          send_item(ACT_UNUSED, 8'($urandom), 16'($urandom), 16'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    int waited;
    quantum_q = 16'd4;
    clear_table();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_quantum_settings();
    test_back_pressure();
    test_random();
    in_ch.valid <= 1'b0;
    waited = 0;
    while (expected_slices.size() != 0 && waited < WATCHDOG) begin
      @(posedge clk);
      waited++;
    end
    repeat (2 * MAX_PROCS + 12) @(posedge clk);
    if (fail_count == 0 && expected_slices.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
